// ===== hdl/delimiter_nesting_tokenizer_assert.svh =====
// Assertion helpers for the tokenizer. Both expect clk and rst in scope.
`ifndef DELIMITER_NESTING_TOKENIZER_ASSERT_SVH
`define DELIMITER_NESTING_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define DNT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dnt_pkg.sv =====
package dnt_pkg;

  localparam int BYTE_W    = 8;
  localparam int TOK_W     = 16;
  localparam int DEPTH_W   = 5;
  localparam int NUM_PAIRS = 3;
  localparam int OUT_W     = 48;

  typedef enum logic [2:0] {
    CLS_CONTENT = 3'd0,
    CLS_ESCAPE  = 3'd1,
    CLS_ESCAPED = 3'd2,
    CLS_OPEN    = 3'd3,
    CLS_CLOSE   = 3'd4,
    CLS_IGNORED = 3'd5
  } byte_class_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_OPEN  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_ESCAPE  = 3'd0,
    REG_OPEN_A  = 3'd1,
    REG_CLOSE_A = 3'd2,
    REG_OPEN_B  = 3'd3,
    REG_CLOSE_B = 3'd4,
    REG_OPEN_C  = 3'd5,
    REG_CLOSE_C = 3'd6,
    REG_PAIRS   = 3'd7
  } cfg_reg_t;

  // Packed lowest field last so byte_class lands in the low bits of tdata.
  typedef struct packed {
    logic [1:0]         pad;
    status_t            status;
    logic [1:0]         last_delim;
    logic [DEPTH_W-1:0] nest_depth;
    logic [TOK_W-1:0]   token_length;
    logic [TOK_W-1:0]   token_begin;
    logic               token_ready;
    byte_class_t        byte_class;
  } result_t;

endpackage

// ===== hdl/delimiter_nesting_tokenizer.sv =====
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   source byte, tlast on final byte
// m_axis    out  m_axis_tvalid/m_axis_tready   one result per byte
// cfg       in   cfg_valid/cfg_ready           register index and 8-bit value
//
// One byte per cycle unless m_axis stalls; a byte is registered, then its result.
// The stack top and the entry below it sit in registers; the stack memory is read
// one entry ahead on each pop, so back-to-back pushes and pops never stall.
// rst is synchronous and clears all control state; no clearing pass is needed.
// A stalled m_axis holds the result register and backs up into s_axis_tready.
`include "delimiter_nesting_tokenizer_assert.svh"

module delimiter_nesting_tokenizer #(
  parameter int STACK_DEPTH = 16,
  parameter int POS_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dnt_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] byte_in
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] byte_class, [3] token_ready, [19:4] token_begin, [35:20] token_length,
  // [40:36] nest_depth, [42:41] last_delim, [45:43] status, [47:46] zero
  output logic [dnt_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [dnt_pkg::BYTE_W-1:0]  cfg_data
);

  import dnt_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // configuration registers
  logic [BYTE_W-1:0] esc_chr;
  logic [BYTE_W-1:0] open_chr  [NUM_PAIRS];
  logic [BYTE_W-1:0] close_chr [NUM_PAIRS];
  logic [1:0]        pairs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_chr      <= 8'd92;
      open_chr[0]  <= 8'd40;
      close_chr[0] <= 8'd41;
      open_chr[1]  <= 8'd91;
      close_chr[1] <= 8'd93;
      open_chr[2]  <= 8'd123;
      close_chr[2] <= 8'd125;
      pairs        <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ESCAPE:  esc_chr      <= cfg_data;
        REG_OPEN_A:  open_chr[0]  <= cfg_data;
        REG_CLOSE_A: close_chr[0] <= cfg_data;
        REG_OPEN_B:  open_chr[1]  <= cfg_data;
        REG_CLOSE_B: close_chr[1] <= cfg_data;
        REG_OPEN_C:  open_chr[2]  <= cfg_data;
        REG_CLOSE_C: close_chr[2] <= cfg_data;
        REG_PAIRS:   pairs        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input register and flow control
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              out_free;
  logic              adv;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign adv           = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // tokenizer state
  logic [CNT_W-1:0]    count, count_next;
  logic [1:0]          top, top_next;
  logic [1:0]          below;
  logic                esc_pend, esc_pend_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [POS_BITS-1:0] tstart, tstart_next;
  status_t             err, err_next;
  logic [1:0]          recent, recent_next;
  logic [1:0]          stack_mem [STACK_DEPTH];

  logic                push, pop, found, tok;
  logic [1:0]          push_code;
  logic [POS_BITS-1:0] tbeg, tlen;
  logic [NUM_PAIRS-1:0] en;
  byte_class_t         cls;
  result_t             res_next;

  assign en[0] = (pairs != 2'd0);
  assign en[1] = (pairs[1] == 1'b1);
  assign en[2] = (pairs == 2'd3);

  always_comb begin
    cls           = CLS_CONTENT;
    tok           = 1'b0;
    tbeg          = '0;
    tlen          = '0;
    push          = 1'b0;
    pop           = 1'b0;
    push_code     = 2'd0;
    found         = 1'b0;
    count_next    = count;
    top_next      = top;
    esc_pend_next = esc_pend;
    pos_next      = pos;
    tstart_next   = tstart;
    err_next      = err;
    recent_next   = recent;

    if (err != ST_OK) begin
      cls = CLS_IGNORED;
    end else if (esc_pend) begin
      esc_pend_next = 1'b0;
      cls           = CLS_ESCAPED;
      pos_next      = pos + 1'b1;
    end else if (in_byte == esc_chr) begin
      esc_pend_next = 1'b1;
      cls           = CLS_ESCAPE;
      pos_next      = pos + 1'b1;
    end else begin
      // pairs in order: matching close pops, then open pushes
      for (int i = 0; i < NUM_PAIRS; i++) begin
        if (!found && en[i]) begin
          if (count != '0 && in_byte == close_chr[i] && top == 2'(i + 1)) begin
            pop         = 1'b1;
            found       = 1'b1;
            cls         = CLS_CLOSE;
            recent_next = 2'd0;
            count_next  = count - 1'b1;
            top_next    = below;
          end else if (in_byte == open_chr[i]) begin
            found = 1'b1;
            cls   = CLS_OPEN;
            if (count == CNT_W'(STACK_DEPTH)) begin
              err_next = ST_OVERFLOW;
            end else begin
              push        = 1'b1;
              push_code   = 2'(i + 1);
              recent_next = 2'(i + 1);
              count_next  = count + 1'b1;
              top_next    = 2'(i + 1);
            end
          end
        end
      end
      // unmatched close
      for (int i = 0; i < NUM_PAIRS; i++) begin
        if (!found && en[i] && in_byte == close_chr[i]) begin
          found    = 1'b1;
          cls      = CLS_CLOSE;
          err_next = (count == '0) ? ST_NO_OPEN : ST_MISMATCH;
        end
      end
      if (found && err_next == ST_OK) begin
        tok         = 1'b1;
        tbeg        = tstart;
        tlen        = pos - tstart;
        tstart_next = pos + 1'b1;
      end
      if (err_next == ST_OK) begin
        pos_next = pos + 1'b1;
      end
    end

    // end of source: open pairs are an error, else flush the final token
    if (cls != CLS_IGNORED && err_next == ST_OK && in_last) begin
      if (count_next != '0) begin
        err_next = ST_UNCLOSED;
      end else if (!tok) begin
        tok         = 1'b1;
        tbeg        = tstart_next;
        tlen        = pos_next - tstart_next;
        tstart_next = pos_next;
      end
    end

    res_next.pad          = 2'b00;
    res_next.status       = err_next;
    res_next.last_delim   = recent_next;
    res_next.nest_depth   = DEPTH_W'(count_next);
    res_next.token_length = TOK_W'(tlen);
    res_next.token_begin  = TOK_W'(tbeg);
    res_next.token_ready  = tok;
    res_next.byte_class   = cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      esc_pend <= 1'b0;
      pos      <= '0;
      tstart   <= '0;
      err      <= ST_OK;
      recent   <= 2'd0;
    end else if (adv) begin
      count    <= count_next;
      esc_pend <= esc_pend_next;
      pos      <= pos_next;
      tstart   <= tstart_next;
      err      <= err_next;
      recent   <= recent_next;
    end
  end

  // stack memory; below holds the entry under the top, prefetched on a pop
  always_ff @(posedge clk) begin
    if (adv) begin
      top <= top_next;
      if (push) begin
        stack_mem[count[IDX_W-1:0]] <= push_code;
        below                        <= top;
      end else if (pop) begin
        below <= stack_mem[IDX_W'(count - CNT_W'(3))];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= res_next;
    end
  end

  `DNT_ASSERT_NEXT(a_err_sticky, err != ST_OK, $stable(err), "error code changed once held")
  `DNT_ASSERT_IMPLY(a_unclosed_depth, err == ST_UNCLOSED, count != '0, "unclosed with empty stack")
  `DNT_ASSERT_IMPLY(a_depth_bound, in_valid, count <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `DNT_ASSERT_NEXT(a_idle_hold, !adv, $stable(pos) && $stable(count), "state moved without an item")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dnt_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata = '0;   // [7:0] byte_in
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] byte_class, [3] token_ready, [19:4] token_begin, [35:20] token_length,
  // [40:36] nest_depth, [42:41] last_delim, [45:43] status, [47:46] zero
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [BYTE_W-1:0]   cfg_data = '0;

  delimiter_nesting_tokenizer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [STACK_DEPTH-1:0][1:0] stack;
    logic [4:0]                  depth;
    logic                        esc;
    logic [15:0]                 pos;
    logic [15:0]                 tok_start;
    status_t                     err;
    logic [1:0]                  recent;
  } scan_state_t;

  scan_state_t scan;
  logic [7:0]  esc_char;
  logic [7:0]  open_ch [3];
  logic [7:0]  close_ch [3];
  logic [1:0]  pairs_on;

  result_t     pending_results [$];
  result_t     got_r;
  result_t     want_r;
  int          fail_count = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;
  int          hold_seen = 0;
  int          hold_count = 0;

  // Next state and result for one byte.
  function automatic result_t scan_byte(inout scan_state_t s, input logic [7:0] b,
                                        input logic last);
    result_t    r;
    int         i;
    logic       hit;
    logic [1:0] top;
    r = '0;
    if (s.err != ST_OK) begin
      r.byte_class = CLS_IGNORED;
    end else if (s.esc) begin
      s.esc = 1'b0;
      r.byte_class = CLS_ESCAPED;
      s.pos = s.pos + 16'd1;
    end else if (b == esc_char) begin
      s.esc = 1'b1;
      r.byte_class = CLS_ESCAPE;
      s.pos = s.pos + 16'd1;
    end else begin
      hit = 1'b0;
      top = (s.depth != 0) ? s.stack[s.depth - 1] : 2'd0;
      for (i = 0; i < pairs_on && !hit; i++) begin
        if (s.depth != 0 && b == close_ch[i] && top == i + 1) begin
          s.depth = s.depth - 5'd1;
          s.recent = 2'd0;
          r.byte_class = CLS_CLOSE;
          hit = 1'b1;
        end else if (b == open_ch[i]) begin
          r.byte_class = CLS_OPEN;
          hit = 1'b1;
          if (s.depth >= STACK_DEPTH) begin
            s.err = ST_OVERFLOW;
          end else begin
            s.stack[s.depth] = 2'(i + 1);
            s.depth = s.depth + 5'd1;
            s.recent = 2'(i + 1);
          end
        end
      end
      // a closer that did not pop is an error
      for (i = 0; i < pairs_on && !hit; i++) begin
        if (b == close_ch[i]) begin
          r.byte_class = CLS_CLOSE;
          hit = 1'b1;
          s.err = (s.depth == 0) ? ST_NO_OPEN : ST_MISMATCH;
        end
      end
      if (hit && s.err == ST_OK) begin
        r.token_ready = 1'b1;
        r.token_begin = s.tok_start;
        r.token_length = s.pos - s.tok_start;
        s.tok_start = s.pos + 16'd1;
      end
      if (s.err == ST_OK) s.pos = s.pos + 16'd1;
    end
    if (r.byte_class != CLS_IGNORED && s.err == ST_OK && last) begin
      if (s.depth != 0) begin
        s.err = ST_UNCLOSED;
      end else if (!r.token_ready) begin
        r.token_ready = 1'b1;
        r.token_begin = s.tok_start;
        r.token_length = s.pos - s.tok_start;
        s.tok_start = s.pos;
      end
    end
    r.nest_depth = s.depth;
    r.last_delim = s.recent;
    r.status = s.err;
    return r;
  endfunction

  function automatic bit keeps_clean(logic [7:0] b, logic last);
    scan_state_t trial;
    trial = scan;
    void'(scan_byte(trial, b, last));
    return trial.err == ST_OK;
  endfunction

  function automatic int top_pair();
    return (scan.depth == 0) ? 0 : int'(scan.stack[scan.depth - 1]);
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result item with nothing expected");
      end else begin
        want_r = pending_results.pop_front();
        check_field("byte_class", want_r.byte_class, got_r.byte_class);
        check_field("token_ready", want_r.token_ready, got_r.token_ready);
        check_field("token_begin", want_r.token_begin, got_r.token_begin);
        check_field("token_length", want_r.token_length, got_r.token_length);
        check_field("nest_depth", want_r.nest_depth, got_r.nest_depth);
        check_field("last_delim", want_r.last_delim, got_r.last_delim);
        check_field("status", want_r.status, got_r.status);
        check_field("pad", want_r.pad, got_r.pad);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_len != hold_seen) begin
      hold_seen = hold_len;
      hold_count = hold_len;
    end
    if (hold_count > 0) begin
      hold_count--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Leaves tvalid high so the next item can follow back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t want;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = scan_byte(scan, b, last);
    pending_results.insert(pending_results.size(), want);
    items_sent++;
  endtask

  // Swaps in a harmless byte when the wanted one would raise an error.
  task automatic send_safe(input logic [7:0] b, input logic last);
    int tries;
    tries = 0;
    while (!keeps_clean(b, last) && tries < 8) begin
      b = 8'($urandom_range(255));
      tries++;
    end
    if (!keeps_clean(b, last)) begin
      b = esc_char;
      last = 1'b0;
    end
    send_byte(b, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ESCAPE:  esc_char = val;
      REG_OPEN_A:  open_ch[0] = val;
      REG_CLOSE_A: close_ch[0] = val;
      REG_OPEN_B:  open_ch[1] = val;
      REG_CLOSE_B: close_ch[1] = val;
      REG_OPEN_C:  open_ch[2] = val;
      REG_CLOSE_C: close_ch[2] = val;
      REG_PAIRS:   pairs_on = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] e, oa, ca, ob, cb, oc, cc, input logic [1:0] p);
    wait_idle();
    write_reg(REG_ESCAPE, e);
    write_reg(REG_OPEN_A, oa);
    write_reg(REG_CLOSE_A, ca);
    write_reg(REG_OPEN_B, ob);
    write_reg(REG_CLOSE_B, cb);
    write_reg(REG_OPEN_C, oc);
    write_reg(REG_CLOSE_C, cc);
    write_reg(REG_PAIRS, {6'd0, p});
  endtask

  task automatic default_config();
    set_config(8'd92, 8'd40, 8'd41, 8'd91, 8'd93, 8'd123, 8'd125, 2'd3);
  endtask

  // Seven distinct bytes; sometimes one pair closes with its own opener.
  task automatic random_config();
    logic [7:0] pick [7];
    logic [7:0] v;
    int         n, j, p;
    bit         dup;
    n = 0;
    while (n < 7) begin
      v = 8'($urandom_range(255));
      dup = 0;
      for (j = 0; j < n; j++) if (pick[j] == v) dup = 1;
      if (!dup) begin
        pick[n] = v;
        n++;
      end
    end
    if ($urandom_range(3) == 0) begin
      p = $urandom_range(2);
      pick[2 + 2 * p] = pick[1 + 2 * p];
    end
    set_config(pick[0], pick[1], pick[2], pick[3], pick[4], pick[5], pick[6],
               2'($urandom_range(3)));
  endtask

  task automatic close_all();
    int guard;
    guard = 0;
    while (scan.depth != 0 && guard < 64) begin
      send_safe(close_ch[top_pair() - 1], 1'b0);
      guard++;
    end
  endtask

  task automatic send_sentence(input int len, input int max_d, input bit end_last);
    int n, roll;
    for (n = 0; n < len; n++) begin
      roll = $urandom_range(99);
      if (roll < 30 && pairs_on != 0 && scan.depth < max_d) begin
        send_safe(open_ch[$urandom_range(pairs_on - 1)], 1'b0);
      end else if (roll < 55 && scan.depth != 0) begin
        send_safe(close_ch[top_pair() - 1], 1'b0);
      end else if (roll < 65) begin
        send_safe(esc_char, 1'b0);
        send_safe(8'($urandom_range(255)), 1'b0);
      end else begin
        send_safe(8'($urandom_range(255)), 1'b0);
      end
    end
    close_all();
    if (end_last) send_safe(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_noise(input int len);
    int n;
    for (n = 0; n < len; n++) send_safe(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  task automatic test_directed();
    send_byte("a", 1'b0);
    send_byte("(", 1'b0);
    send_byte("[", 1'b0);
    send_byte("{", 1'b0);
    send_byte("\\", 1'b0);
    send_byte("}", 1'b0);      // escaped, not taken as a closer
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("}", 1'b0);
    send_byte("]", 1'b0);
    send_byte(")", 1'b0);
    send_byte("(", 1'b0);
    send_byte(")", 1'b1);      // token already ended by the closer
    send_byte("b", 1'b1);
    send_byte("\\", 1'b1);     // escape still pending at the last byte
    send_byte(")", 1'b0);
    send_byte("x", 1'b0);
    send_byte("y", 1'b1);
    send_byte("(", 1'b0);
    send_byte("(", 1'b0);      // zero-length tokens
    send_byte(")", 1'b0);
    send_byte(")", 1'b0);
    wait_idle();
  endtask

  task automatic test_full_nesting();
    int n;
    for (n = 0; n < STACK_DEPTH; n++) send_byte(open_ch[n % 3], 1'b0);
    close_all();
    send_byte("z", 1'b1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_config(8'h00, 8'hFF, 8'hFE, 8'h01, 8'h02, 8'h80, 8'h7F, 2'd3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_sentence(30, 16, 1'b1);

    // no pairs: delimiters are plain content
    set_config(8'd92, 8'd40, 8'd41, 8'd91, 8'd93, 8'd123, 8'd125, 2'd0);
    send_byte("(", 1'b0);
    send_byte(")", 1'b0);
    send_byte("]", 1'b0);
    send_byte("}", 1'b1);
    set_config(8'd92, 8'd40, 8'd41, 8'd91, 8'd93, 8'd123, 8'd125, 2'd1);
    send_byte("[", 1'b0);
    send_byte("(", 1'b0);
    send_byte("]", 1'b0);
    send_byte(")", 1'b1);
    set_config(8'd92, 8'd40, 8'd41, 8'd91, 8'd93, 8'd123, 8'd125, 2'd2);
    send_byte("{", 1'b0);
    send_byte("[", 1'b0);
    send_byte("}", 1'b0);
    send_byte("]", 1'b1);

    // quote-like pairs: same byte opens and closes
    set_config(8'hFF, 8'h22, 8'h22, 8'h00, 8'h01, 8'h7C, 8'h7C, 2'd3);
    send_byte(8'h22, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h7C, 1'b0);
    send_byte(8'h7C, 1'b0);
    send_byte(8'h22, 1'b0);
    send_sentence(30, 8, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    default_config();
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 300;
    send_sentence(60, 10, 1'b1);
    send_noise(30);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int idle_set [4];
    int stall_set [4];
    int ph, mark, roll;
    idle_set = '{0, 79, 0, 17};
    stall_set = '{0, 0, 79, 17};
    for (ph = 0; ph < 4; ph++) begin
      random_config();
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      mark = items_sent;
      while (items_sent - mark < 300) begin
        roll = $urandom_range(99);
        if (roll < 15)
          send_noise($urandom_range(1, 20));
        else
          send_sentence($urandom_range(1, 40),
                        ($urandom_range(7) == 0) ? STACK_DEPTH : $urandom_range(1, 6),
                        $urandom_range(2) == 0);
      end
      wait_idle();
    end
  endtask

  // One error per run, since only reset clears it; the kind is random.
  task automatic test_sticky_error();
    int kind, n;
    default_config();
    idle_pct = 17;
    stall_pct = 17;
    send_byte("a", 1'b0);
    kind = $urandom_range(1, 4);
    case (kind)
      1: send_byte(")", 1'b0);
      2: begin
        send_byte("(", 1'b0);
        send_byte("]", 1'b0);
      end
      3: begin
        send_byte("(", 1'b0);
        send_byte("b", 1'b1);
      end
      default: for (n = 0; n <= STACK_DEPTH; n++) send_byte("[", 1'b0);
    endcase
    for (n = 0; n < 20; n++) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_idle();
  endtask

  initial begin
    scan = '0;
    esc_char = 8'd92;
    open_ch = '{8'd40, 8'd91, 8'd123};
    close_ch = '{8'd41, 8'd93, 8'd125};
    pairs_on = 2'd3;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_nesting();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    test_sticky_error();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
